// File: rtl/scpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scpa_pkg
// Shared codes and widths for the size-class pool allocator.
// ----------------------------------------------------------------------------
package scpa_pkg;

    localparam int LIMIT_W = 10;
    localparam int SIZE_W  = 16;
    localparam int SLOT_W  = 10;
    localparam int USAGE_W = 21;
    localparam int CNT_W   = 32;
    localparam int TOT_W   = 48;

    typedef enum logic [0:0] {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        CLS_SMALL  = 2'd0,
        CLS_MEDIUM = 2'd1,
        CLS_LARGE  = 2'd2,
        CLS_NONE   = 2'd3
    } cls_t;

    typedef enum logic [2:0] {
        ST_GRANTED  = 3'd0,
        ST_RELEASED = 3'd1,
        ST_NO_SLOT  = 3'd2,
        ST_RANGE    = 3'd3,
        ST_DOUBLE   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CFG_SMALL  = 2'd0,
        CFG_MEDIUM = 2'd1,
        CFG_LARGE  = 2'd2
    } cfg_idx_t;

endpackage
`default_nettype wire

// File: rtl/size_class_pool_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// size_class_pool_allocator_unit
// Three fixed-slot pools with LIFO freed stacks and per-slot size records.
// ----------------------------------------------------------------------------
//  channel | signals                                     | direction
//  cfg     | cfg_we, cfg_index, cfg_data                 | in, write only
//  request | in_valid/in_ready, req_type .. free_slot    | in
//  result  | out_valid/out_ready, status .. totals       | out
//
//  Each request passes decode and memory read at the transfer, then modify
//  with write-back, then the result register, held until transferred. One
//  request is in flight at a time; the single-port slot-info and stack reads
//  set this. After reset a clearing pass zeroes the slot records (size and
//  allocated mark); in_ready stays low until it ends. Counters clear at
//  reset. A stalled result holds the next request at the input.
// ----------------------------------------------------------------------------
module size_class_pool_allocator_unit #(
    parameter int SMALL_SLOTS  = 1024,
    parameter int MEDIUM_SLOTS = 256,
    parameter int LARGE_SLOTS  = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [9:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        req_type,
    input  wire logic [15:0] request_size,
    input  wire logic [1:0]  free_class,
    input  wire logic [9:0]  free_slot,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [1:0]       grant_class,
    output logic [9:0]       grant_slot,
    output logic [9:0]       block_bytes,
    output logic [20:0]      usage_now,
    output logic [20:0]      usage_peak,
    output logic [31:0]      small_grants,
    output logic [31:0]      medium_grants,
    output logic [31:0]      large_grants,
    output logic [31:0]      refused_requests,
    output logic [47:0]      bytes_granted_total,
    output logic [47:0]      bytes_released_total
);
    import scpa_pkg::*;

    localparam int SA = (SMALL_SLOTS  > 1) ? $clog2(SMALL_SLOTS)  : 1;
    localparam int MA = (MEDIUM_SLOTS > 1) ? $clog2(MEDIUM_SLOTS) : 1;
    localparam int LA = (LARGE_SLOTS  > 1) ? $clog2(LARGE_SLOTS)  : 1;
    localparam int DW = 11;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_OUT
    } state_t;

    state_t state_reg;
    logic [9:0] clr_reg;

    logic [9:0] small_limit_reg, medium_limit_reg, large_limit_reg;

    // memories: freed stacks and slot records {allocated mark, size}
    logic [SA-1:0] small_stack  [SMALL_SLOTS];
    logic [MA-1:0] medium_stack [MEDIUM_SLOTS];
    logic [LA-1:0] large_stack  [LARGE_SLOTS];
    logic [10:0]   small_info   [SMALL_SLOTS];
    logic [10:0]   medium_info  [MEDIUM_SLOTS];
    logic [10:0]   large_info   [LARGE_SLOTS];

    logic [DW-1:0] fdep_reg [3];
    logic [DW-1:0] untch_reg [3];

    logic [20:0] usage_reg, peak_reg;
    logic [31:0] cnt_reg [4];
    logic [47:0] gtot_reg, rtot_reg;

    // latched request
    logic        alloc_reg;
    logic [1:0]  cls_reg;
    logic [9:0]  slot_reg;
    logic [15:0] size_reg;
    logic        ok_reg;     // class valid and slot in range / pop available
    logic        pop_stk_reg;
    logic [10:0] rd_info_reg;
    logic [SA-1:0] s_stk_q;
    logic [MA-1:0] m_stk_q;
    logic [LA-1:0] l_stk_q;

    // result
    logic [2:0] st_reg;
    logic [1:0] gc_reg;
    logic [9:0] gs_reg, gb_reg;

    // decode at accept
    logic [1:0]  dec_cls;
    logic        dec_ok, dec_pop;
    logic [9:0]  dec_slot;
    logic [DW-1:0] cap_c;

    logic [9:0]  alloc_slot;
    logic [20:0] usage_next;

    function automatic logic [DW-1:0] cap_of(input logic [1:0] c);
        unique case (c)
            CLS_SMALL:  cap_of = DW'(SMALL_SLOTS);
            CLS_MEDIUM: cap_of = DW'(MEDIUM_SLOTS);
            default:    cap_of = DW'(LARGE_SLOTS);
        endcase
    endfunction

    // slot granted on allocate: popped stack entry or latched untouched index
    function automatic logic [9:0] gs_slot();
        if (!pop_stk_reg) gs_slot = slot_reg;
        else begin
            unique case (cls_reg)
                CLS_SMALL:  gs_slot = 10'(s_stk_q);
                CLS_MEDIUM: gs_slot = 10'(m_stk_q);
                default:    gs_slot = 10'(l_stk_q);
            endcase
        end
    endfunction

    always_comb
    begin
        dec_pop  = 1'b0;
        dec_slot = free_slot;
        if (req_type == REQ_ALLOC) begin
            if (request_size <= {6'd0, small_limit_reg})       dec_cls = CLS_SMALL;
            else if (request_size <= {6'd0, medium_limit_reg}) dec_cls = CLS_MEDIUM;
            else if (request_size <= {6'd0, large_limit_reg})  dec_cls = CLS_LARGE;
            else                                               dec_cls = CLS_NONE;
            dec_ok = 1'b0;
            if (dec_cls != CLS_NONE) begin
                if (fdep_reg[dec_cls] != '0) begin
                    dec_ok  = 1'b1;
                    dec_pop = 1'b1;
                    dec_slot = 10'(fdep_reg[dec_cls] - DW'(1));
                end else if (untch_reg[dec_cls] != '0) begin
                    dec_ok  = 1'b1;
                    dec_slot = 10'(untch_reg[dec_cls] - DW'(1));
                end
            end
        end else begin
            dec_cls = free_class;
            dec_ok  = (free_class != CLS_NONE)
                   && ({1'b0, free_slot} < cap_of(free_class));
        end
        cap_c = cap_of(cls_reg);
    end

    assign alloc_slot = gs_slot();
    assign usage_next = usage_reg + 21'(size_reg);

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk)
    begin
        // stack reads: address is the depth-1 or unused
        s_stk_q <= small_stack[SA'(dec_slot)];
        m_stk_q <= medium_stack[MA'(dec_slot)];
        l_stk_q <= large_stack[LA'(dec_slot)];
        if (state_reg == S_CLEAR) begin
            small_info[SA'(clr_reg)]  <= '0;
            medium_info[MA'(clr_reg)] <= '0;
            large_info[LA'(clr_reg)]  <= '0;
        end
        if (state_reg == S_IDLE) begin
            unique case (dec_cls)
                CLS_SMALL:  rd_info_reg <= small_info[SA'(free_slot)];
                CLS_MEDIUM: rd_info_reg <= medium_info[MA'(free_slot)];
                default:    rd_info_reg <= large_info[LA'(free_slot)];
            endcase
        end
        if (state_reg == S_MOD && ok_reg) begin
            if (alloc_reg) begin
                unique case (cls_reg)
                    CLS_SMALL:  small_info[SA'(alloc_slot)]  <= {1'b1, size_reg[9:0]};
                    CLS_MEDIUM: medium_info[MA'(alloc_slot)] <= {1'b1, size_reg[9:0]};
                    default:    large_info[LA'(alloc_slot)]  <= {1'b1, size_reg[9:0]};
                endcase
            end else if (rd_info_reg[10]) begin
                // drop the allocated mark, keep the recorded size
                unique case (cls_reg)
                    CLS_SMALL:  small_info[SA'(slot_reg)]  <= {1'b0, rd_info_reg[9:0]};
                    CLS_MEDIUM: medium_info[MA'(slot_reg)] <= {1'b0, rd_info_reg[9:0]};
                    default:    large_info[LA'(slot_reg)]  <= {1'b0, rd_info_reg[9:0]};
                endcase
                if (fdep_reg[cls_reg] < cap_c) begin
                    unique case (cls_reg)
                        CLS_SMALL:  small_stack[SA'(fdep_reg[cls_reg])]  <= SA'(slot_reg);
                        CLS_MEDIUM: medium_stack[MA'(fdep_reg[cls_reg])] <= MA'(slot_reg);
                        default:    large_stack[LA'(fdep_reg[cls_reg])]  <= LA'(slot_reg);
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            small_limit_reg  <= 10'd24;
            medium_limit_reg <= 10'd216;
            large_limit_reg  <= 10'd984;
            fdep_reg[0]  <= '0;
            fdep_reg[1]  <= '0;
            fdep_reg[2]  <= '0;
            untch_reg[0] <= DW'(SMALL_SLOTS);
            untch_reg[1] <= DW'(MEDIUM_SLOTS);
            untch_reg[2] <= DW'(LARGE_SLOTS);
            usage_reg <= '0;
            peak_reg  <= '0;
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
            cnt_reg[2] <= '0;
            cnt_reg[3] <= '0;
            gtot_reg <= '0;
            rtot_reg <= '0;
            alloc_reg <= 1'b0;
            cls_reg   <= CLS_SMALL;
            slot_reg  <= '0;
            size_reg  <= '0;
            ok_reg    <= 1'b0;
            pop_stk_reg <= 1'b0;
            st_reg    <= ST_GRANTED;
            gc_reg    <= '0;
            gs_reg    <= '0;
            gb_reg    <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_SMALL:  small_limit_reg  <= cfg_data;
                    CFG_MEDIUM: medium_limit_reg <= cfg_data;
                    CFG_LARGE:  large_limit_reg  <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 10'd1;
                    if (clr_reg == 10'h3FF) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_valid) begin
                        alloc_reg   <= (req_type == REQ_ALLOC);
                        cls_reg     <= dec_cls;
                        slot_reg    <= dec_slot;
                        size_reg    <= request_size;
                        ok_reg      <= dec_ok;
                        pop_stk_reg <= dec_pop;
                        state_reg   <= S_MOD;
                        if (req_type == REQ_ALLOC && dec_ok) begin
                            // advance pointers now; the slot itself comes later
                            if (dec_pop) fdep_reg[dec_cls] <= fdep_reg[dec_cls] - DW'(1);
                            else untch_reg[dec_cls] <= untch_reg[dec_cls] - DW'(1);
                        end
                    end
                end
                S_MOD: begin
                    state_reg <= S_OUT;
                    gc_reg <= '0;
                    gs_reg <= '0;
                    gb_reg <= '0;
                    if (alloc_reg) begin
                        if (ok_reg && ({1'b0, alloc_slot} < {1'b0, cap_c})) begin
                            cnt_reg[cls_reg] <= cnt_reg[cls_reg] + 32'd1;
                            usage_reg <= usage_next;
                            if (usage_next > peak_reg) peak_reg <= usage_next;
                            gtot_reg <= gtot_reg + 48'(size_reg);
                            st_reg <= ST_GRANTED;
                            gc_reg <= cls_reg;
                            gs_reg <= alloc_slot;
                            gb_reg <= size_reg[9:0];
                        end else begin
                            cnt_reg[3] <= cnt_reg[3] + 32'd1;
                            st_reg <= ST_NO_SLOT;
                        end
                    end else if (!ok_reg) begin
                        st_reg <= ST_RANGE;
                    end else if (!rd_info_reg[10]) begin
                        st_reg <= ST_DOUBLE;
                    end else begin
                        if (fdep_reg[cls_reg] < cap_c)
                            fdep_reg[cls_reg] <= fdep_reg[cls_reg] + DW'(1);
                        usage_reg <= usage_reg - 21'(rd_info_reg[9:0]);
                        rtot_reg  <= rtot_reg + 48'(rd_info_reg[9:0]);
                        st_reg <= ST_RELEASED;
                        gc_reg <= cls_reg;
                        gs_reg <= slot_reg;
                        gb_reg <= rd_info_reg[9:0];
                    end
                end
                default: begin
                    if (out_ready) state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid            = (state_reg == S_OUT);
    assign status               = st_reg;
    assign grant_class          = gc_reg;
    assign grant_slot           = gs_reg;
    assign block_bytes          = gb_reg;
    assign usage_now            = usage_reg;
    assign usage_peak           = peak_reg;
    assign small_grants         = cnt_reg[0];
    assign medium_grants        = cnt_reg[1];
    assign large_grants         = cnt_reg[2];
    assign refused_requests     = cnt_reg[3];
    assign bytes_granted_total  = gtot_reg;
    assign bytes_released_total = rtot_reg;

endmodule
`default_nettype wire

// File: rtl/scpa_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scpa_checker
// Port-level checks for the size-class pool allocator.
// ----------------------------------------------------------------------------
module scpa_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  status,
    input wire logic [9:0]  grant_slot,
    input wire logic [20:0] usage_now,
    input wire logic [20:0] usage_peak
);
    import scpa_pkg::*;

    // hold the request until transferred
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("request withdrawn before transfer");

    // hold the result until transferred
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped while stalled");

    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("request taken while result pending");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NO_SLOT || status == ST_RANGE
                      || status == ST_DOUBLE) |-> grant_slot == 10'd0)
        else $error("error result carries a slot");

    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_GRANTED |-> usage_peak >= usage_now)
        else $error("peak below usage after grant");

endmodule

bind size_class_pool_allocator_unit scpa_checker u_scpa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .grant_slot (grant_slot),
    .usage_now  (usage_now),
    .usage_peak (usage_peak)
);
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Size-class pool allocator regression
// Drives allocate and free requests with random gaps on both channels, keeps
// its own model of the pools, slot records and statistics, and compares every
// result field against the predicted value in order.
// ----------------------------------------------------------------------------
module testbench;
    import scpa_pkg::*;

    localparam int N_SMALL  = 1024;
    localparam int N_MEDIUM = 256;
    localparam int N_LARGE  = 64;
    localparam int STALL_LIMIT = 8000;

    typedef struct packed {
        status_t     st;
        logic [1:0]  cls;
        logic [9:0]  slot;
        logic [9:0]  bytes;
        logic [20:0] use_now;
        logic [20:0] use_peak;
        logic [31:0] n_small;
        logic [31:0] n_medium;
        logic [31:0] n_large;
        logic [31:0] n_refused;
        logic [47:0] tot_granted;
        logic [47:0] tot_released;
    } outcome_t;

    // Pool model and the queue of outcomes still owed by the block.
    class pool_scoreboard;
        logic [9:0]  lim [3];
        int          freed_stack [3][$];
        int          untouched [3];
        logic [10:0] slot_info [3][N_SMALL];
        outcome_t    cur;
        outcome_t    owed [$];
        int          mismatches;

        function int capacity(int c);
            return (c == 0) ? N_SMALL : (c == 1) ? N_MEDIUM : N_LARGE;
        endfunction

        function void clear();
            int c;
            lim[0] = 10'd24;
            lim[1] = 10'd216;
            lim[2] = 10'd984;
            for (c = 0; c < 3; c++)
            begin
                freed_stack[c].delete();
                untouched[c] = capacity(c);
                for (int s = 0; s < N_SMALL; s++) slot_info[c][s] = '0;
            end
            cur = '0;
            owed.delete();
            mismatches = 0;
        endfunction

        function void note_request(req_t rq, logic [15:0] sz, logic [1:0] fc,
                                   logic [9:0] fs);
            int c;
            int s;
            logic [9:0] b;
            cur.st = ST_NO_SLOT;
            cur.cls = '0;
            cur.slot = '0;
            cur.bytes = '0;
            if (rq == REQ_ALLOC)
            begin
                c = (sz <= lim[0]) ? 0 : (sz <= lim[1]) ? 1 : (sz <= lim[2]) ? 2 : 3;
                s = -1;
                if (c < 3)
                begin
                    if (freed_stack[c].size() > 0) s = freed_stack[c].pop_back();
                    else if (untouched[c] > 0)
                    begin
                        untouched[c]--;
                        s = untouched[c];
                    end
                end
                if (s >= 0)
                begin
                    slot_info[c][s] = {1'b1, sz[9:0]};
                    cur.st = ST_GRANTED;
                    cur.cls = c[1:0];
                    cur.slot = s[9:0];
                    cur.bytes = sz[9:0];
                    cur.use_now = cur.use_now + 21'(sz);
                    if (cur.use_now > cur.use_peak) cur.use_peak = cur.use_now;
                    cur.tot_granted = cur.tot_granted + 48'(sz);
                    if (c == 0) cur.n_small++;
                    else if (c == 1) cur.n_medium++;
                    else cur.n_large++;
                end
                else cur.n_refused++;
            end
            else if (fc == CLS_NONE || fs >= capacity(fc)) cur.st = ST_RANGE;
            else if (!slot_info[fc][fs][10]) cur.st = ST_DOUBLE;
            else
            begin
                b = slot_info[fc][fs][9:0];
                freed_stack[fc].push_back(fs);
                slot_info[fc][fs] = {1'b0, b};
                cur.use_now = cur.use_now - 21'(b);
                cur.tot_released = cur.tot_released + 48'(b);
                cur.st = ST_RELEASED;
                cur.cls = fc;
                cur.slot = fs;
                cur.bytes = b;
            end
            owed.push_back(cur);
        endfunction

        function void check_result(outcome_t got);
            outcome_t want;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = owed.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch\n  expected %p\n  actual   %p", want, got);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [9:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        req_type = 1'b0;
    logic [15:0] request_size = '0;
    logic [1:0]  free_class = '0;
    logic [9:0]  free_slot = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [1:0]  grant_class;
    logic [9:0]  grant_slot, block_bytes;
    logic [20:0] usage_now, usage_peak;
    logic [31:0] small_grants, medium_grants, large_grants, refused_requests;
    logic [47:0] bytes_granted_total, bytes_released_total;

    pool_scoreboard board;
    int  idle_cycles = 0;
    bit  rx_quiet = 1'b0;
    // Live allocations, for well-formed frees.
    int  held_class [$];
    int  held_slot [$];

    size_class_pool_allocator_unit uut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("size_class_pool_allocator_unit regression: fail");
            $finish;
        end
    end

    // Result side: random stall before each transfer, none while rx_quiet is set.
    initial
    begin : result_side
        int w;
        @(posedge rst_n);
        forever
        begin
            w = rx_quiet ? 0 : $urandom_range(0, 5);
            if (w > 0)
            begin
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            board.check_result({status_t'(status), grant_class, grant_slot, block_bytes,
                                usage_now, usage_peak, small_grants, medium_grants,
                                large_grants, refused_requests, bytes_granted_total,
                                bytes_released_total});
        end
    end

    task automatic write_limit(cfg_idx_t idx, logic [9:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.lim[idx] = v;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.owed.size() > 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send(req_t rq, logic [15:0] sz, logic [1:0] fc, logic [9:0] fs,
                        bit gaps = 1'b1);
        int w;
        w = gaps ? $urandom_range(0, 5) : 0;
        if (w > 0)
        begin
            in_valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        request_size <= sz;
        free_class <= fc;
        free_slot <= fs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_request(rq, sz, fc, fs);
        if (rq == REQ_ALLOC && board.cur.st == ST_GRANTED)
        begin
            held_class.push_back(board.cur.cls);
            held_slot.push_back(board.cur.slot);
        end
        if (rq == REQ_FREE && board.cur.st == ST_RELEASED)
            foreach (held_class[k])
                if (held_class[k] == fc && held_slot[k] == fs)
                begin
                    held_class.delete(k);
                    held_slot.delete(k);
                    break;
                end
    endtask

    task automatic free_random_held(bit gaps);
        int k;
        k = $urandom_range(0, held_class.size() - 1);
        send(REQ_FREE, 16'($urandom), held_class[k][1:0], held_slot[k][9:0], gaps);
    endtask

    initial
    begin : stimulus
        int i;
        int r;
        board = new();
        board.clear();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: class boundaries, oversize, bad frees, double free.
        send(REQ_ALLOC, 16'd0, 2'd0, 10'd0);
        send(REQ_ALLOC, 16'd24, 2'd0, 10'd0);
        send(REQ_ALLOC, 16'd25, 2'd0, 10'd0);
        send(REQ_ALLOC, 16'd216, 2'd0, 10'd0);
        send(REQ_ALLOC, 16'd217, 2'd0, 10'd0);
        send(REQ_ALLOC, 16'd984, 2'd0, 10'd0);
        send(REQ_ALLOC, 16'd985, 2'd0, 10'd0);
        send(REQ_ALLOC, 16'hFFFF, 2'd3, 10'h3FF);
        send(REQ_FREE, 16'd0, CLS_NONE, 10'd0);
        send(REQ_FREE, 16'd0, CLS_LARGE, 10'd64);
        send(REQ_FREE, 16'd0, CLS_MEDIUM, 10'h3FF);
        send(REQ_FREE, 16'hFFFF, CLS_SMALL, 10'd5);
        send(REQ_FREE, 16'd0, CLS_SMALL, 10'h3FF);
        send(REQ_FREE, 16'd0, CLS_SMALL, 10'h3FF);
        send(REQ_FREE, 16'd0, CLS_LARGE, 10'd63, 1'b0);
        send(REQ_ALLOC, 16'd500, 2'd0, 10'd0, 1'b0);
        send(REQ_FREE, 16'd0, CLS_SMALL, 10'd1023, 1'b0);
        send(REQ_ALLOC, 16'd7, 2'd0, 10'd0, 1'b0);
        drain();

        // Exhaust the large pool under tiny small and medium limits.
        write_limit(CFG_SMALL, 10'd0);
        write_limit(CFG_MEDIUM, 10'd1);
        write_limit(CFG_LARGE, 10'h3FF);
        for (i = 0; i < 66; i++)
            send(REQ_ALLOC, 16'($urandom_range(2, 1023)), 2'd0, 10'd0, i[0]);
        send(REQ_ALLOC, 16'd1024, 2'd0, 10'd0);
        send(REQ_ALLOC, 16'd0, 2'd0, 10'd0);
        send(REQ_ALLOC, 16'd1, 2'd0, 10'd0);
        drain();

        // Random phases under several limit settings.
        for (r = 0; r < 4; r++)
        begin
            case (r)
                0: begin write_limit(CFG_SMALL, 10'd24); write_limit(CFG_MEDIUM, 10'd216);
                       write_limit(CFG_LARGE, 10'd984); end
                1: begin write_limit(CFG_SMALL, 10'h3FF); write_limit(CFG_MEDIUM, 10'h3FF);
                       write_limit(CFG_LARGE, 10'h3FF); end
                2: begin write_limit(CFG_SMALL, 10'd0); write_limit(CFG_MEDIUM, 10'd0);
                       write_limit(CFG_LARGE, 10'd0); end
                default: begin write_limit(CFG_SMALL, 10'($urandom));
                       write_limit(CFG_MEDIUM, 10'($urandom));
                       write_limit(CFG_LARGE, 10'($urandom)); end
            endcase
            rx_quiet = (r == 1);
            for (i = 0; i < 120; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                        send(REQ_ALLOC, ($urandom_range(0, 7) == 0) ? 16'($urandom)
                             : 16'($urandom_range(0, 1023)), 2'($urandom), 10'($urandom),
                             r != 1);
                    4, 5, 6:
                        if (held_class.size() > 0) free_random_held(r != 1);
                        else send(REQ_ALLOC, 16'($urandom_range(0, 300)), 2'd0, 10'd0,
                                  r != 1);
                    7:
                        send(REQ_FREE, 16'($urandom), 2'($urandom), 10'($urandom), r != 1);
                    default:
                        send(REQ_FREE, 16'($urandom), 2'($urandom_range(0, 2)),
                             10'($urandom_range(0, 63)), r != 1);
                endcase
            end
            drain();
        end

        if (board.mismatches == 0 && board.owed.size() == 0)
            $display("size_class_pool_allocator_unit regression: pass");
        else
            $display("size_class_pool_allocator_unit regression: fail");
        $finish;
    end
endmodule
